// ----- design/fcf_pkg.sv -----
// ----------------------------------------------------------------------------
// fcf_pkg: shared types and constants for the folded Fletcher page checksum
// Holds the channel payload types, the configuration register map and the
// byte masks and substitute value used by the checksum datapath.
// ----------------------------------------------------------------------------
package fcf_pkg;

	// Masks that clear the checksum field (page bytes 2-3) of the first word
	localparam logic [63:0] MASK_LE       = 64'hFFFF_FFFF_0000_FFFF;
	localparam logic [63:0] MASK_BE       = 64'hFFFF_0000_FFFF_FFFF;
	localparam logic [15:0] NONZERO_SUBST = 16'hAFFE;

	// Configuration register map, indexed by paddr[2]
	typedef enum logic {
		REG_LITTLE_ENDIAN  = 1'b0,
		REG_NO_CHECK_MAGIC = 1'b1
	} fcf_reg_t;

	typedef struct packed {
		logic [63:0] data_word;
		logic        last_word;
	} fcf_word_t;

	typedef struct packed {
		logic [15:0] checksum;
		logic [15:0] stored_checksum;
		logic        checksum_match;
		logic        not_checked;
	} fcf_result_t;

	// Final sums of one page, handed from the accumulator to the fold stage
	typedef struct packed {
		logic [63:0] first_sum;
		logic [63:0] second_sum;
		logic [15:0] stored_sum;
	} fcf_page_t;

	typedef struct packed {
		logic        little_endian;
		logic [15:0] no_check_magic;
	} fcf_cfg_t;

endpackage

// ----- design/fcf_stream_if.sv -----
// ----------------------------------------------------------------------------
// fcf_stream_if: valid/ready channel
// Carries one payload item per request; a request moves when valid and
// ready are both high at a rising clock edge.
// ----------------------------------------------------------------------------
interface fcf_stream_if #(
	parameter type payload_t = logic
);
	logic     valid;
	logic     ready;
	payload_t payload;

	modport source (output valid, output payload, input ready);
	modport sink   (input valid, input payload, output ready);
endinterface

// ----- design/fcf_accum.sv -----
// ----------------------------------------------------------------------------
// fcf_accum: input register and Fletcher accumulators
// Registers each word, masks the checksum field on the first word of a page,
// runs both 64-bit sums and hands the final sums of each page downstream.
// ----------------------------------------------------------------------------
module fcf_accum import fcf_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	fcf_stream_if.sink          words,
	input  logic                little_endian,
	output fcf_page_t           page_s2,
	output logic                page_valid_s2,
	input  logic                page_ready
);

	logic        valid_s1;
	logic [63:0] word_s1;
	logic        last_s1;
	logic        ready_s1;
	logic        consume;

	logic [63:0] first_q;
	logic [63:0] second_q;
	logic [15:0] held_q;
	logic        start_q;

	logic [63:0] masked;
	logic [15:0] stored;
	logic [63:0] first_new;
	logic [63:0] second_new;
	logic [15:0] held_new;

	// A non-last word always drains; a last word needs room for its page record
	assign consume  = valid_s1 && (!last_s1 || !page_valid_s2 || page_ready);
	assign ready_s1 = !valid_s1 || consume;
	assign words.ready = ready_s1;

	always_comb begin
		if (little_endian) begin
			masked = word_s1 & MASK_LE;
			stored = word_s1[31:16];
		end else begin
			masked = word_s1 & MASK_BE;
			stored = word_s1[47:32];
		end
		if (start_q) begin
			first_new  = masked;
			second_new = masked;
			held_new   = stored;
		end else begin
			first_new  = first_q + word_s1;
			second_new = second_q + first_q + word_s1;
			held_new   = held_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (ready_s1) begin
			valid_s1 <= words.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (words.valid && ready_s1) begin
			word_s1 <= words.payload.data_word;
			last_s1 <= words.payload.last_word;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			first_q  <= '0;
			second_q <= '0;
			held_q   <= '0;
			start_q  <= 1'b1;
		end else if (consume) begin
			if (last_s1) begin
				first_q  <= '0;
				second_q <= '0;
				start_q  <= 1'b1;
			end else begin
				first_q  <= first_new;
				second_q <= second_new;
				start_q  <= 1'b0;
			end
			held_q <= held_new;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			page_valid_s2 <= 1'b0;
		end else if (consume && last_s1) begin
			page_valid_s2 <= 1'b1;
		end else if (page_ready) begin
			page_valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (consume && last_s1) begin
			page_s2.first_sum  <= first_new;
			page_s2.second_sum <= second_new;
			page_s2.stored_sum <= held_new;
		end
	end

endmodule

// ----- design/fcf_fold.sv -----
// ----------------------------------------------------------------------------
// fcf_fold: checksum fold and result register
// Adds the two page sums, folds the total to 16 bits by end-around carry,
// compares against the stored and magic values and holds the result.
// ----------------------------------------------------------------------------
module fcf_fold import fcf_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  fcf_page_t           page_s2,
	input  logic                page_valid_s2,
	output logic                page_ready,
	input  logic [15:0]         no_check_magic,
	fcf_stream_if.source        results
);

	logic        out_valid_q;
	fcf_result_t out_q;
	logic        out_free;

	logic [63:0] total;
	logic [17:0] fold_a;
	logic [16:0] fold_b;
	logic [15:0] fold_c;
	logic [15:0] chk;

	assign out_free   = !out_valid_q || results.ready;
	assign page_ready = out_free;

	// Four 16-bit chunks, then two end-around carries
	always_comb begin
		total  = page_s2.first_sum + page_s2.second_sum;
		fold_a = 18'(total[15:0]) + 18'(total[31:16]) + 18'(total[47:32])
			+ 18'(total[63:48]);
		fold_b = 17'(fold_a[15:0]) + 17'(fold_a[17:16]);
		fold_c = fold_b[15:0] + 16'(fold_b[16]);
		chk    = (fold_c == 16'd0) ? NONZERO_SUBST : fold_c;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q <= page_valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (out_free && page_valid_s2) begin
			out_q.checksum        <= chk;
			out_q.stored_checksum <= page_s2.stored_sum;
			out_q.checksum_match  <= (page_s2.stored_sum == chk);
			out_q.not_checked     <= (page_s2.stored_sum == no_check_magic);
		end
	end

	assign results.valid   = out_valid_q;
	assign results.payload = out_q;

endmodule

// ----- design/page_checksum_fletcher64_fold16.sv -----
// ----------------------------------------------------------------------------
// page_checksum_fletcher64_fold16: folded Fletcher-64 page checksum
// Streams page words through two wrapping 64-bit sums and returns one
// 16-bit checksum record per page, with the stored value and match flags.
// ----------------------------------------------------------------------------
//
//   port        direction  payload                                 per request
//   ----------  ---------  --------------------------------------  ---------------
//   words       sink       data_word[63:0], last_word              one page word
//   results     source     checksum, stored_checksum,              one per page,
//                          checksum_match, not_checked             on its last word
//   APB (p*)    slave      reg 0 little_endian @0x0,               register write
//                          reg 1 no_check_magic @0x4
//
// One word is accepted every cycle unless a last word waits for the page register;
// an accepted word loads the word register, a last word's sums then load the page
// register and its record the result register, each once the next stage has room.
// Reset (arst_n low) empties all stages, clears both sums, marks the next word
// as a page start and sets little_endian to 1 and no_check_magic to 0.
// A stalled results channel holds its record; words keep flowing while the
// internal page register has room, since only last words occupy it.
// ----------------------------------------------------------------------------
module page_checksum_fletcher64_fold16 import fcf_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	fcf_stream_if.sink  words,
	fcf_stream_if.source results,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	fcf_cfg_t  cfg_q;
	fcf_reg_t  reg_sel;
	logic      cfg_wr;

	fcf_page_t page_s2;
	logic      page_valid_s2;
	logic      page_ready;

	// Register index from the word address; byte lanes are ignored
	assign reg_sel = fcf_reg_t'(paddr[2]);
	assign pready  = 1'b1;
	assign cfg_wr  = psel && penable && pwrite && pready;

	// Hold configuration; writes must arrive only while the datapath is idle (not enforced here)
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.little_endian  <= 1'b1;
			cfg_q.no_check_magic <= 16'd0;
		end else if (cfg_wr) begin
			case (reg_sel)
				REG_LITTLE_ENDIAN:  cfg_q.little_endian  <= pwdata[0];
				REG_NO_CHECK_MAGIC: cfg_q.no_check_magic <= pwdata[15:0];
				default:            cfg_q <= cfg_q;
			endcase
		end
	end

	always_comb begin
		case (reg_sel)
			REG_LITTLE_ENDIAN:  prdata = {31'd0, cfg_q.little_endian};
			REG_NO_CHECK_MAGIC: prdata = {16'd0, cfg_q.no_check_magic};
			default:            prdata = 32'd0;
		endcase
	end

	// Advance words through the accumulators; only last words emit a page record
	fcf_accum u_accum (
		.clk           (clk),
		.arst_n        (arst_n),
		.words         (words),
		.little_endian (cfg_q.little_endian),
		.page_s2       (page_s2),
		.page_valid_s2 (page_valid_s2),
		.page_ready    (page_ready)
	);

	// Fold the page sums and hold the result until it is taken
	fcf_fold u_fold (
		.clk            (clk),
		.arst_n         (arst_n),
		.page_s2        (page_s2),
		.page_valid_s2  (page_valid_s2),
		.page_ready     (page_ready),
		.no_check_magic (cfg_q.no_check_magic),
		.results        (results)
	);

endmodule

// ----- design/fcf_checker.sv -----
// ----------------------------------------------------------------------------
// fcf_checker: port-level assertions for the page checksum block
// Tracks pages in flight between last words and results and checks the
// result record against itself and the pipeline depth.
// ----------------------------------------------------------------------------
module fcf_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_ready,
	input logic        in_last,
	input logic        out_valid,
	input logic        out_ready,
	input logic [15:0] out_checksum,
	input logic [15:0] out_stored,
	input logic        out_match
);

	logic [2:0] pending_q;
	logic       page_in;
	logic       page_out;

	assign page_in  = in_valid && in_ready && in_last;
	assign page_out = out_valid && out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pending_q <= 3'd0;
		end else begin
			pending_q <= pending_q + 3'(page_in) - 3'(page_out);
		end
	end

	a_checksum_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> out_checksum != 16'd0)
		else $error("result checksum is zero");

	a_match_flag: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> out_match == (out_stored == out_checksum))
		else $error("match flag disagrees with checksum fields");

	a_no_invented_result: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> pending_q != 3'd0)
		else $error("result without an accepted last word");

	a_depth_bound: assert property (@(posedge clk) disable iff (!arst_n)
		pending_q <= 3'd3)
		else $error("more pages in flight than pipeline stages");

	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_checksum))
		else $error("stalled result changed");

endmodule

bind page_checksum_fletcher64_fold16 fcf_checker u_fcf_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.in_valid     (words.valid),
	.in_ready     (words.ready),
	.in_last      (words.payload.last_word),
	.out_valid    (results.valid),
	.out_ready    (results.ready),
	.out_checksum (results.payload.checksum),
	.out_stored   (results.payload.stored_checksum),
	.out_match    (results.payload.checksum_match)
);

// ----- verif/page_checksum_fletcher64_fold16_tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// page_checksum_fletcher64_fold16_tb: self-checking bench for the page checksum
// Streams pages of 64-bit words into the block and rebuilds each page result
// with an in-bench accumulator model: masked first word, two wrapping sums,
// end-around fold with the zero substitute, stored field and both flags.
// Covers register access, directed corner pages, a register change in the
// middle of a page and random pages under random stalls on both channels.
// ----------------------------------------------------------------------------
module page_checksum_fletcher64_fold16_tb import fcf_pkg::*; ();

	localparam int HALF_PERIOD  = 10;
	localparam int PIPE_SETTLE  = 8;     // settle time after the last result so stray results can show
	localparam int STALL_LIMIT  = 1000;  // cycles with no request moving anywhere
	localparam int RANDOM_WORDS = 1000;
	localparam int PHASES       = 8;

	// How the checksum field of a page's first word is filled
	typedef enum int {
		FIELD_KEEP,
		FIELD_MATCH,
		FIELD_MAGIC
	} field_sel_t;

	logic        clk;
	logic        arst_n;
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [2:0]  paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;

	fcf_stream_if #(.payload_t(fcf_word_t))   words_if ();
	fcf_stream_if #(.payload_t(fcf_result_t)) results_if ();

	page_checksum_fletcher64_fold16 u_dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.words   (words_if),
		.results (results_if),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	// Accumulator model state and register shadow
	logic [63:0]  run_sum;
	logic [63:0]  run_sum_of_sums;
	logic [15:0]  held_field;
	logic         page_start;
	logic         cfg_le;
	logic [15:0]  cfg_magic;

	fcf_result_t  page_results_due[$];

	int           error_count;
	int           words_sent;
	int           idle_cycles;
	int           gap_max;
	int           stall_max;

	initial clk = 1'b0;
	always #HALF_PERIOD clk = ~clk;

	// ------------------------------------------------------------------------
	// Checksum arithmetic
	// ------------------------------------------------------------------------

	// Fold by end-around carry until 16 bits remain; zero becomes the substitute
	function automatic logic [15:0] fold_to_16(input logic [63:0] total);
		logic [63:0] s;
		s = total;
		while (s[63:16] != '0)
			s = {48'b0, s[15:0]} + {16'b0, s[63:16]};
		if (s == '0)
			return NONZERO_SUBST;
		return s[15:0];
	endfunction

	function automatic logic [63:0] strip_field(input logic [63:0] w, input logic le);
		return le ? (w & MASK_LE) : (w & MASK_BE);
	endfunction

	// Checksum a whole page ahead of time, so stimulus can plant a matching field
	function automatic logic [15:0] page_checksum(input logic [63:0] w[$]);
		logic [63:0] a;
		logic [63:0] b;
		a = strip_field(w[0], cfg_le);
		b = a;
		for (int i = 1; i < w.size(); i++) begin
			a = a + w[i];
			b = b + a;
		end
		return fold_to_16(a + b);
	endfunction

	function automatic logic [63:0] with_field(input logic [63:0] w, input logic [15:0] v);
		logic [63:0] r;
		r = w;
		if (cfg_le)
			r[31:16] = v;
		else
			r[47:32] = v;
		return r;
	endfunction

	// Advance the model by one accepted word; queue the page result on a last word
	task automatic predict_page_word(input logic [63:0] d, input logic last);
		fcf_result_t r;
		if (page_start) begin
			held_field      = cfg_le ? d[31:16] : d[47:32];
			run_sum         = strip_field(d, cfg_le);
			run_sum_of_sums = run_sum;
			page_start      = 1'b0;
		end else begin
			run_sum         = run_sum + d;
			run_sum_of_sums = run_sum_of_sums + run_sum;
		end
		if (last) begin
			r.checksum        = fold_to_16(run_sum + run_sum_of_sums);
			r.stored_checksum = held_field;
			r.checksum_match  = (held_field == r.checksum);
			r.not_checked     = (held_field == cfg_magic);
			page_results_due.push_back(r);
			run_sum         = '0;
			run_sum_of_sums = '0;
			page_start      = 1'b1;
		end
	endtask

	// ------------------------------------------------------------------------
	// Reporting and watchdog
	// ------------------------------------------------------------------------

	task automatic report_mismatch(input string what, input logic [63:0] want,
			input logic [63:0] got);
		$display("[%0t] MISMATCH %s: expected %0h, got %0h", $realtime, what, want, got);
		error_count++;
	endtask

	// Reset the count whenever any request moves; trip when the block hangs
	always @(posedge clk) begin
		if ((words_if.valid && words_if.ready) || (results_if.valid && results_if.ready)
				|| (psel && penable && pready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= STALL_LIMIT) begin
			$display("[%0t] timeout: no request moved for %0d cycles", $realtime, STALL_LIMIT);
			$display("Regression FAIL");
			$finish;
		end
	end

	// ------------------------------------------------------------------------
	// Result side: random backpressure and field-by-field compare
	// ------------------------------------------------------------------------

	// Draw a stall for every result; hold ready high until the request moves
	initial begin
		int n;
		wait (arst_n === 1'b1);
		forever begin
			@(negedge clk);
			n = $urandom_range(0, stall_max);
			if (n > 0) begin
				results_if.ready <= 1'b0;
				repeat (n) @(negedge clk);
			end
			results_if.ready <= 1'b1;
			@(posedge clk);
			while (!results_if.valid) @(posedge clk);
		end
	end

	always @(posedge clk) begin
		fcf_result_t want;
		fcf_result_t got;
		if (arst_n && results_if.valid && results_if.ready) begin
			got = results_if.payload;
			if (page_results_due.size() == 0) begin
				report_mismatch("result with no page pending", '0, 64'(got));
			end else begin
				want = page_results_due.pop_front();
				if (got.checksum !== want.checksum)
					report_mismatch("checksum", 64'(want.checksum), 64'(got.checksum));
				if (got.stored_checksum !== want.stored_checksum)
					report_mismatch("stored_checksum", 64'(want.stored_checksum),
						64'(got.stored_checksum));
				if (got.checksum_match !== want.checksum_match)
					report_mismatch("checksum_match", 64'(want.checksum_match),
						64'(got.checksum_match));
				if (got.not_checked !== want.not_checked)
					report_mismatch("not_checked", 64'(want.not_checked),
						64'(got.not_checked));
			end
		end
	end

	// ------------------------------------------------------------------------
	// Word side and register port
	// ------------------------------------------------------------------------

	// Send one word request; keep valid high when no gap is drawn
	task automatic send_word(input logic [63:0] d, input logic last);
		fcf_word_t item;
		int        gap;
		item.data_word = d;
		item.last_word = last;
		gap = $urandom_range(0, gap_max);
		@(negedge clk);
		if (gap > 0) begin
			words_if.valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		words_if.valid   <= 1'b1;
		words_if.payload <= item;
		@(posedge clk);
		while (!words_if.ready) @(posedge clk);
		predict_page_word(d, last);
		words_sent++;
	endtask

	task automatic words_idle();
		@(negedge clk);
		words_if.valid <= 1'b0;
	endtask

	// Drop valid, wait out every pending result, then let the pipeline empty
	task automatic drain_idle();
		words_idle();
		while (page_results_due.size() != 0) @(posedge clk);
		repeat (PIPE_SETTLE) @(posedge clk);
	endtask

	task automatic send_page(input logic [63:0] w[$], input field_sel_t sel);
		case (sel)
			FIELD_MATCH: w[0] = with_field(w[0], page_checksum(w));
			FIELD_MAGIC: w[0] = with_field(w[0], cfg_magic);
			default: ;
		endcase
		foreach (w[i])
			send_word(w[i], i == w.size() - 1);
	endtask

	// Setup phase, access phase, register written at the access edge
	task automatic apb_write(input fcf_reg_t r, input logic [31:0] v);
		@(negedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {r, 2'b00};
		pwdata  <= v;
		@(negedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		case (r)
			REG_LITTLE_ENDIAN:  cfg_le    = v[0];
			REG_NO_CHECK_MAGIC: cfg_magic = v[15:0];
			default: ;
		endcase
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
	endtask

	// Read back a register and compare against the shadow copy
	task automatic apb_read_check(input fcf_reg_t r);
		logic [31:0] want;
		@(negedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		paddr   <= {r, 2'b00};
		@(negedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		want = (r == REG_LITTLE_ENDIAN) ? {31'b0, cfg_le} : {16'b0, cfg_magic};
		if (prdata !== want)
			report_mismatch(r.name(), 64'(want), 64'(prdata));
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
	endtask

	// Mix of zero, all-ones, one-hot and fully random words
	function automatic logic [63:0] rand_page_word();
		logic [63:0] w;
		case ($urandom_range(0, 7))
			0: w = '0;
			1: w = '1;
			2: w = 64'd1 << $urandom_range(0, 63);
			default: w = {$urandom, $urandom};
		endcase
		return w;
	endfunction

	// ------------------------------------------------------------------------
	// Tests
	// ------------------------------------------------------------------------

	// Reset values, both extremes, and bits above each register's width dropped
	task automatic test_register_access();
		apb_read_check(REG_LITTLE_ENDIAN);
		apb_read_check(REG_NO_CHECK_MAGIC);
		apb_write(REG_LITTLE_ENDIAN, 32'hFFFF_FFFE);
		apb_read_check(REG_LITTLE_ENDIAN);
		apb_write(REG_LITTLE_ENDIAN, 32'h8000_0001);
		apb_read_check(REG_LITTLE_ENDIAN);
		apb_write(REG_NO_CHECK_MAGIC, 32'hFFFF_FFFF);
		apb_read_check(REG_NO_CHECK_MAGIC);
		apb_write(REG_NO_CHECK_MAGIC, 32'hABCD_0000);
		apb_read_check(REG_NO_CHECK_MAGIC);
	endtask

	// Corner pages under both byte orders
	task automatic test_directed_pages();
		logic [63:0] pg[$];
		gap_max   = 0;
		stall_max = 0;
		// zero page folds to zero and takes the substitute; field equals magic 0
		send_page('{64'h0}, FIELD_KEEP);
		send_page('{64'hFFFF_FFFF_FFFF_FFFF}, FIELD_KEEP);
		// all-ones words wrap both 64-bit sums
		send_page('{'1, '1, '1, '1}, FIELD_KEEP);
		send_page('{64'h0000_0000_0000_0001, 64'h8000_0000_0000_0000}, FIELD_MATCH);
		send_page('{64'h1234_5678_9ABC_DEF0}, FIELD_MATCH);
		drain_idle();
		// big-endian layout, written with the upper bits set
		apb_write(REG_LITTLE_ENDIAN, 32'hFFFF_FFFE);
		apb_write(REG_NO_CHECK_MAGIC, 32'h1234_FFFF);
		gap_max   = 10;
		stall_max = 10;
		send_page('{64'hFFFF_FFFF_FFFF_FFFF}, FIELD_KEEP);
		send_page('{64'hDEAD_BEEF_0BAD_F00D, 64'h0123_4567_89AB_CDEF}, FIELD_MATCH);
		send_page('{64'h0000_FFFF_0000_0000, 64'h0}, FIELD_KEEP);
		// stored value equals both the magic and the computed checksum
		pg = '{64'hCAFE_0000_1111_2222, 64'h7777_8888_9999_AAAA};
		drain_idle();
		apb_write(REG_NO_CHECK_MAGIC, {16'h0, page_checksum(pg)});
		send_page(pg, FIELD_MATCH);
		drain_idle();
	endtask

	// Byte order latched by the first word only; magic read when the page ends
	task automatic test_midpage_config();
		apb_write(REG_LITTLE_ENDIAN, 32'h1);
		apb_write(REG_NO_CHECK_MAGIC, 32'h0);
		send_word(64'h0102_0304_5A5A_0708, 1'b0);
		send_word(64'hFFFF_0000_FFFF_0000, 1'b0);
		drain_idle();
		apb_write(REG_LITTLE_ENDIAN, 32'h0);
		apb_write(REG_NO_CHECK_MAGIC, 32'h5A5A);
		send_word(64'h1111_2222_3333_4444, 1'b1);
		// next page picks up the new byte order
		send_word(64'h0000_5A5A_0000_0000, 1'b1);
		drain_idle();
	endtask

	// Random pages in phases; each phase sets both registers and an idling mix
	task automatic test_random_pages();
		logic [63:0] pg[$];
		logic [31:0] rnd;
		logic        le;
		logic [15:0] magic;
		int          target;
		int          len;
		int          pick;
		for (int phase = 0; phase < PHASES; phase++) begin
			drain_idle();
			le  = (phase < 2) ? phase[0] : 1'($urandom_range(0, 1));
			rnd = $urandom;
			apb_write(REG_LITTLE_ENDIAN, {rnd[31:1], le});
			case (phase % 3)
				0: magic = 16'h0000;
				1: magic = 16'hFFFF;
				default: magic = 16'($urandom_range(0, 16'hFFFF));
			endcase
			rnd = $urandom;
			apb_write(REG_NO_CHECK_MAGIC, {rnd[31:16], magic});
			// hold some phases free of gaps or stalls, give others gaps, stalls or both
			gap_max   = phase[0] ? 10 : 0;
			stall_max = phase[1] ? 10 : 0;
			target    = words_sent + RANDOM_WORDS / PHASES;
			while (words_sent < target) begin
				len = ($urandom_range(0, 9) == 0) ? $urandom_range(17, 64)
					: $urandom_range(1, 8);
				pg.delete();
				repeat (len) pg.push_back(rand_page_word());
				pick = $urandom_range(0, 3);
				if (pick == 2)
					send_page(pg, FIELD_MATCH);
				else if (pick == 3)
					send_page(pg, FIELD_MAGIC);
				else
					send_page(pg, FIELD_KEEP);
			end
		end
	endtask

	// ------------------------------------------------------------------------
	// Sequence
	// ------------------------------------------------------------------------

	initial begin
		arst_n             = 1'b0;
		psel               = 1'b0;
		penable            = 1'b0;
		pwrite             = 1'b0;
		paddr              = '0;
		pwdata             = '0;
		words_if.valid     = 1'b0;
		words_if.payload   = '0;
		results_if.ready   = 1'b0;
		run_sum            = '0;
		run_sum_of_sums    = '0;
		held_field         = '0;
		page_start         = 1'b1;
		cfg_le             = 1'b1;
		cfg_magic          = '0;
		error_count        = 0;
		words_sent         = 0;
		idle_cycles        = 0;
		gap_max            = 0;
		stall_max          = 0;

		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		test_register_access();
		test_directed_pages();
		test_midpage_config();
		test_random_pages();

		// wait for the last page result, then give stray results time to show
		drain_idle();
		if (error_count == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule
